/* design/tme_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tme_pkg
// Shared types, operation codes and constants of the tape machine executor.
// ----------------------------------------------------------------------------
package tme_pkg;

  localparam int unsigned TAPE_DEPTH_DEF = 32768;
  localparam logic [15:0] TAPE_SIZE_RST  = 16'd30000;

  typedef enum logic [2:0] {
    FN_ADD   = 3'd0,
    FN_MOVE  = 3'd1,
    FN_READ  = 3'd2,
    FN_WRITE = 3'd3,
    FN_JZ    = 3'd4,
    FN_JNZ   = 3'd5
  } func_e;

  typedef struct packed {
    func_e       func;
    logic [15:0] amount;
    logic [7:0]  in_byte;
  } item_t;

  // Width that holds both a tape size register value and the tape depth itself.
  function automatic int size_w(input int depth);
    int w;
    w = $clog2(depth + 1);
    return (w > 16) ? w : 16;
  endfunction

endpackage
`default_nettype wire

/* design/tape_machine_executor_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tape_machine_executor_core
// Executes one preprocessed tape machine instruction per command beat.
//   The command channel (cmd_valid_i / cmd_stall_o) carries one instruction per
//   beat: func, amount and input byte. The result channel (res_valid_o /
//   res_stall_i) returns one beat per instruction with the next program counter
//   for the fetcher and, for a write, the emitted byte. The configuration channel
//   (cfg_valid_i / cfg_ready_o) sets the tape size; it is always ready and should
//   only be written while the block is idle.
//   A command beat is registered in the execute stage and its result in the
//   result register. Throughput: one instruction per cycle unless stalled,
//   set by the single read-modify-write of the tape memory with the last
//   written byte forwarded to the next read. A move that leaves the tape by
//   more than one wrap (a pointer left beyond a shrunk tape) runs the
//   remainder unit; commands are stalled meanwhile.
//   Reset: the tape is zeroed by a clearing pass over all TAPE_DEPTH cells, during
//   which cmd_stall_o stays high. Pointer and program counter reset to zero.
//   When the receiver stalls, the result register holds its beat; a command
//   already in the execute stage waits, and further commands are stalled.
// ----------------------------------------------------------------------------
module tape_machine_executor_core #(
  parameter int unsigned TAPE_DEPTH = tme_pkg::TAPE_DEPTH_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // command channel
  input  wire logic               cmd_valid_i,
  output logic                    cmd_stall_o,
  input  wire logic [2:0]         cmd_func_i,
  input  wire logic signed [15:0] cmd_amount_i,
  input  wire logic [7:0]         cmd_input_byte_i,
  // result channel
  output logic                    res_valid_o,
  input  wire logic               res_stall_i,
  output logic [15:0]             next_pc_o,
  output logic                    out_valid_o,
  output logic [7:0]              out_byte_o,
  // configuration channel
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [15:0]        cfg_data_i
);
  import tme_pkg::*;

  localparam int PW = $clog2(TAPE_DEPTH);
  localparam int CW = size_w(TAPE_DEPTH);

  // configuration
  logic [15:0]   tape_size_q;
  logic [CW-1:0] ts_ext, depth_c, eff_size;

  // clearing pass
  logic          clr_busy_q;
  logic [PW-1:0] clr_addr_q;

  // pointer unit
  logic [PW-1:0] ptr;
  logic          ptr_busy;

  // execute stage
  logic          s1_vld_q;
  item_t         s1_item_q;
  logic [PW-1:0] s1_addr_q;
  logic          fwd_q;
  logic [7:0]    fwd_data_q;
  logic [15:0]   pc_q;

  // result register
  logic          res_vld_q;
  logic [15:0]   res_pc_q;
  logic          res_ov_q;
  logic [7:0]    res_byte_q;

  logic          cmd_acc, s1_adv;
  logic [7:0]    rd_data, cur_cell;
  logic          s1_wr, s1_ov;
  logic [7:0]    s1_wdata, s1_obyte;
  logic [15:0]   s1_next, jmp_pc;
  logic          mem_we;
  logic [PW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;

  always_comb begin
    ts_ext   = CW'(tape_size_q);
    depth_c  = CW'(TAPE_DEPTH);
    eff_size = ((ts_ext == '0) || (ts_ext > depth_c)) ? depth_c : ts_ext;
  end

  assign s1_adv      = s1_vld_q && (!res_vld_q || !res_stall_i);
  assign cmd_stall_o = clr_busy_q || ptr_busy || (s1_vld_q && !s1_adv);
  assign cmd_acc     = cmd_valid_i && !cmd_stall_o;
  assign cfg_ready_o = 1'b1;

  tme_ptr_unit #(
    .TAPE_DEPTH(TAPE_DEPTH)
  ) u_ptr (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_acc && (cmd_func_i == FN_MOVE)),
    .amount_i(cmd_amount_i),
    .size_i  (eff_size),
    .ptr_o   (ptr),
    .busy_o  (ptr_busy)
  );

  // The clearing pass owns the write port until it ends.
  assign mem_we    = clr_busy_q || (s1_adv && s1_wr);
  assign mem_waddr = clr_busy_q ? clr_addr_q : s1_addr_q;
  assign mem_wdata = clr_busy_q ? 8'd0 : s1_wdata;

  tme_tape_ram #(
    .TAPE_DEPTH(TAPE_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (cmd_acc),
    .raddr_i(ptr),
    .rdata_o(rd_data)
  );

  // A read issued at the edge that writes the same cell sees the old byte,
  // so the written byte is kept aside and used instead.
  assign cur_cell = fwd_q ? fwd_data_q : rd_data;
  assign jmp_pc   = s1_item_q.amount + 16'd1;

  always_comb begin
    s1_wr    = 1'b0;
    s1_wdata = cur_cell;
    s1_ov    = 1'b0;
    s1_obyte = 8'd0;
    s1_next  = pc_q + 16'd1;
    unique case (s1_item_q.func)
      FN_ADD: begin
        s1_wr    = 1'b1;
        s1_wdata = cur_cell + s1_item_q.amount[7:0];
      end
      FN_READ: begin
        s1_wr    = 1'b1;
        s1_wdata = s1_item_q.in_byte;
      end
      FN_WRITE: begin
        s1_ov    = 1'b1;
        s1_obyte = cur_cell;
      end
      FN_JZ: begin
        if (cur_cell == 8'd0) begin
          s1_next = jmp_pc;
        end
      end
      FN_JNZ: begin
        if (cur_cell != 8'd0) begin
          s1_next = jmp_pc;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tape_size_q <= TAPE_SIZE_RST;
      clr_busy_q  <= 1'b1;
      clr_addr_q  <= '0;
      s1_vld_q    <= 1'b0;
      fwd_q       <= 1'b0;
      pc_q        <= '0;
      res_vld_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        tape_size_q <= cfg_data_i;
      end
      if (clr_busy_q) begin
        clr_addr_q <= clr_addr_q + PW'(1);
        if (clr_addr_q == PW'(TAPE_DEPTH - 1)) begin
          clr_busy_q <= 1'b0;
        end
      end
      if (cmd_acc) begin
        s1_vld_q <= 1'b1;
        fwd_q    <= s1_adv && s1_wr && (s1_addr_q == ptr);
      end else if (s1_adv) begin
        s1_vld_q <= 1'b0;
      end
      if (s1_adv) begin
        pc_q      <= s1_next;
        res_vld_q <= 1'b1;
      end else if (!res_stall_i) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_acc) begin
      s1_item_q.func    <= func_e'(cmd_func_i);
      s1_item_q.amount  <= cmd_amount_i;
      s1_item_q.in_byte <= cmd_input_byte_i;
      s1_addr_q         <= ptr;
      fwd_data_q        <= s1_wdata;
    end
    if (s1_adv) begin
      res_pc_q   <= s1_next;
      res_ov_q   <= s1_ov;
      res_byte_q <= s1_obyte;
    end
  end

  assign res_valid_o = res_vld_q;
  assign next_pc_o   = res_pc_q;
  assign out_valid_o = res_ov_q;
  assign out_byte_o  = res_byte_q;

endmodule
`default_nettype wire

/* design/tme_tape_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tme_tape_ram
// Byte-wide tape memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tme_tape_ram #(
  parameter int unsigned TAPE_DEPTH = tme_pkg::TAPE_DEPTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          we_i,
  input  wire logic [$clog2(TAPE_DEPTH)-1:0] waddr_i,
  input  wire logic [7:0]                    wdata_i,
  input  wire logic                          re_i,
  input  wire logic [$clog2(TAPE_DEPTH)-1:0] raddr_i,
  output logic      [7:0]                    rdata_o
);
  import tme_pkg::*;

  logic [7:0] mem [TAPE_DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

/* design/tme_ptr_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tme_ptr_unit
// Cell pointer register with its move logic. A move that lands within one
// wrap of the tape is done in the cycle it is accepted; any other move runs a
// restoring remainder over the pointer sum, one bit per cycle.
// ----------------------------------------------------------------------------
module tme_ptr_unit #(
  parameter int unsigned TAPE_DEPTH = tme_pkg::TAPE_DEPTH_DEF
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic                                    start_i,
  input  wire logic [15:0]                             amount_i,
  input  wire logic [tme_pkg::size_w(TAPE_DEPTH)-1:0]  size_i,
  output logic      [$clog2(TAPE_DEPTH)-1:0]           ptr_o,
  output logic                                         busy_o
);
  import tme_pkg::*;

  localparam int PW = $clog2(TAPE_DEPTH);
  localparam int CW = size_w(TAPE_DEPTH);
  localparam int SW = ((PW > 16) ? PW : 16) + 2;
  localparam int MW = SW - 1;
  localparam int NW = $clog2(SW);

  logic [PW-1:0] ptr_q, ptr_d;
  logic          busy_q, busy_d;
  logic [NW-1:0] cnt_q, cnt_d;
  logic          neg_q;
  logic [MW-1:0] mag_q;
  logic [CW-1:0] rem_q;
  logic [CW-1:0] dsize_q;

  logic signed [SW-1:0] sum_s, size_s, up_s, dn_s, neg_sum_s;
  logic [MW-1:0]        mag;
  logic                 fast;
  logic [PW-1:0]        fast_val;
  logic [CW:0]          rem_sh, rem_nx;
  logic [CW-1:0]        rem_nx_c, fin_r;

  always_comb begin
    sum_s     = $signed({{(SW-PW){1'b0}}, ptr_q}) +
                $signed({{(SW-16){amount_i[15]}}, amount_i});
    size_s    = $signed({{(SW-CW){1'b0}}, size_i});
    up_s      = sum_s + size_s;
    dn_s      = sum_s - size_s;
    neg_sum_s = -sum_s;
    mag       = sum_s[SW-1] ? neg_sum_s[MW-1:0] : sum_s[MW-1:0];

    fast     = 1'b1;
    fast_val = sum_s[PW-1:0];
    priority if (!sum_s[SW-1] && (sum_s < size_s)) begin
      fast_val = sum_s[PW-1:0];
    end else if (sum_s[SW-1] && !up_s[SW-1]) begin
      fast_val = up_s[PW-1:0];
    end else if (!sum_s[SW-1] && (dn_s < size_s)) begin
      fast_val = dn_s[PW-1:0];
    end else begin
      fast = 1'b0;
    end
  end

  // One restoring step of the remainder.
  always_comb begin
    rem_sh   = {rem_q, mag_q[MW-1]};
    rem_nx   = (rem_sh >= {1'b0, dsize_q}) ? (rem_sh - {1'b0, dsize_q}) : rem_sh;
    rem_nx_c = rem_nx[CW-1:0];
    fin_r    = (neg_q && (rem_nx_c != '0)) ? (dsize_q - rem_nx_c) : rem_nx_c;
  end

  always_comb begin
    ptr_d  = ptr_q;
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (busy_q) begin
      cnt_d = cnt_q - NW'(1);
      if (cnt_q == NW'(1)) begin
        busy_d = 1'b0;
        ptr_d  = fin_r[PW-1:0];
      end
    end else if (start_i) begin
      if (fast) begin
        ptr_d = fast_val;
      end else begin
        busy_d = 1'b1;
        cnt_d  = NW'(MW);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q  <= '0;
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      ptr_q  <= ptr_d;
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      rem_q <= rem_nx_c;
      mag_q <= {mag_q[MW-2:0], 1'b0};
    end else if (start_i && !fast) begin
      rem_q   <= '0;
      mag_q   <= mag;
      neg_q   <= sum_s[SW-1];
      dsize_q <= size_i;
    end
  end

  assign ptr_o  = ptr_q;
  assign busy_o = busy_q;

endmodule
`default_nettype wire

/* design/tme_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tme_checker
// Port-level checks of the tape machine executor, bound to its top level.
// ----------------------------------------------------------------------------
module tme_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               cmd_valid_i,
  input wire logic               cmd_stall_o,
  input wire logic [2:0]         cmd_func_i,
  input wire logic signed [15:0] cmd_amount_i,
  input wire logic [7:0]         cmd_input_byte_i,
  input wire logic               res_valid_o,
  input wire logic               res_stall_i,
  input wire logic [15:0]        next_pc_o,
  input wire logic               out_valid_o,
  input wire logic [7:0]         out_byte_o,
  input wire logic               cfg_valid_i,
  input wire logic               cfg_ready_o,
  input wire logic [15:0]        cfg_data_i
);
  import tme_pkg::*;

  // A stalled result beat keeps its content.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_stall_i |=> res_valid_o && $stable(next_pc_o) &&
      $stable(out_valid_o) && $stable(out_byte_o))
    else $error("stalled result beat changed");

  // Only a write instruction carries a byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !out_valid_o |-> out_byte_o == 8'd0)
    else $error("byte present on a result without output");

  // A result that appears on an idle channel comes from an accepted command
  // beat that went straight through the execute stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_o) |-> $past(cmd_valid_i && !cmd_stall_o, 2))
    else $error("result without a matching command beat");

  // Commands are held off while the tape is cleared after reset.
  assert property (@(posedge clk_i)
    $rose(rst_ni) |-> cmd_stall_o)
    else $error("command accepted before tape clear");

endmodule

bind tape_machine_executor_core tme_checker u_tme_checker (.*);
`default_nettype wire
